// File: rtl/core/anpt_pkg.sv
// Package for the ARM next-PC target unit.
// Result kinds, instruction class and opcode codes, and the result struct.
// No dependencies.
package anpt_pkg;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DIRECT = 2'd1,
        KIND_LOAD   = 2'd2
    } t_target_kind;

    // instruction bits 27:25
    localparam logic [2:0] CLS_DP_REG  = 3'b000;
    localparam logic [2:0] CLS_DP_IMM  = 3'b001;
    localparam logic [2:0] CLS_LS_IMM  = 3'b010;
    localparam logic [2:0] CLS_LS_REG  = 3'b011;
    localparam logic [2:0] CLS_LDM     = 3'b100;
    localparam logic [2:0] CLS_BRANCH  = 3'b101;

    // data-processing opcodes, bits 24:21
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_SBC = 4'd6;
    localparam logic [3:0] OP_RSC = 4'd7;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_CMN = 4'd11;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;
    localparam logic [3:0] OP_BIC = 4'd14;
    localparam logic [3:0] OP_MVN = 4'd15;

    // shift types, bits 6:5
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [3:0] REG_PC  = 4'hF;
    localparam logic [3:0] COND_AL = 4'hE;

    localparam logic [31:0] PC_MASK_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        t_target_kind kind;
        logic [31:0]  target;
        logic         fall;
        logic [31:0]  fall_addr;
    } t_result;

endpackage

// File: rtl/core/anpt_shifter.sv
// Operand shifter for the ARM next-PC target unit.
// Immediate-count and register-count shifts of Rm. Uses anpt_pkg.
module anpt_shifter import anpt_pkg::*; (
    input  logic [31:0] i_value,
    input  logic [1:0]  i_type,
    input  logic        i_by_reg,
    input  logic [4:0]  i_imm_amt,
    input  logic [7:0]  i_reg_amt,
    input  logic        i_carry,
    output logic [31:0] o_value
);

    logic [31:0] imm_res;
    logic [31:0] reg_res;
    logic [31:0] ror_imm;
    logic [31:0] ror_reg;

    assign ror_imm = (i_value >> i_imm_amt) | (i_value << (6'd32 - {1'b0, i_imm_amt}));
    assign ror_reg = (i_value >> i_reg_amt[4:0])
                   | (i_value << (6'd32 - {1'b0, i_reg_amt[4:0]}));

    always_comb begin
        case (i_type)
            SH_LSL: imm_res = i_value << i_imm_amt;
            SH_LSR: imm_res = (i_imm_amt == 5'd0) ? 32'd0 : (i_value >> i_imm_amt);
            SH_ASR: imm_res = (i_imm_amt == 5'd0) ? {32{i_value[31]}}
                                                  : 32'($signed(i_value) >>> i_imm_amt);
            default: imm_res = (i_imm_amt == 5'd0) ? {i_carry, i_value[31:1]} : ror_imm;
        endcase
    end

    always_comb begin
        if (i_reg_amt == 8'd0) begin
            reg_res = i_value;
        end else begin
            case (i_type)
                SH_LSL:  reg_res = i_value << i_reg_amt;
                SH_LSR:  reg_res = i_value >> i_reg_amt;
                SH_ASR:  reg_res = 32'($signed(i_value) >>> i_reg_amt);
                default: reg_res = (i_reg_amt[4:0] == 5'd0) ? i_value : ror_reg;
            endcase
        end
    end

    assign o_value = i_by_reg ? reg_res : imm_res;

endmodule

// File: rtl/core/anpt_target.sv
// Next-PC target logic: decode, ALU, load and branch address forms.
// Uses anpt_pkg and anpt_shifter.
module anpt_target import anpt_pkg::*; (
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_instr_address,
    input  logic [31:0] i_rn_value,
    input  logic [31:0] i_rm_value,
    input  logic [31:0] i_rs_value,
    input  logic        i_carry_flag,
    input  logic [31:0] i_pc_mask,
    output t_result     o_result
);

    logic [31:0] insn;
    logic [31:0] rn;
    logic [2:0]  cls;
    logic        is_dp;
    logic [31:0] sh_val;
    logic [31:0] op2;
    logic [31:0] alt;
    logic [31:0] rot_imm;
    logic [3:0]  rot;
    logic [31:0] ls_off;
    logic [31:0] ls_addr;
    logic [4:0]  reg_cnt;
    logic [31:0] ldm_off;
    logic [31:0] br_disp;
    logic [31:0] br_tgt;
    logic [31:0] cin;

    assign insn  = i_instruction;
    assign rn    = (insn[19:16] == REG_PC) ? (i_rn_value & i_pc_mask) : i_rn_value;
    assign cls   = insn[27:25];
    assign is_dp = (cls == CLS_DP_REG) || (cls == CLS_DP_IMM);
    assign cin   = {31'd0, i_carry_flag};

    anpt_shifter u_shifter (
        .i_value   (i_rm_value),
        .i_type    (insn[6:5]),
        .i_by_reg  (is_dp && insn[4]),
        .i_imm_amt (insn[11:7]),
        .i_reg_amt (i_rs_value[7:0]),
        .i_carry   (i_carry_flag),
        .o_value   (sh_val)
    );

    // immediate operand: imm8 rotated right by twice the rotate field
    assign rot     = insn[11:8];
    assign rot_imm = ({24'd0, insn[7:0]} >> {rot, 1'b0})
                   | ({24'd0, insn[7:0]} << (6'd32 - {1'b0, rot, 1'b0}));
    assign op2     = insn[25] ? rot_imm : sh_val;

    always_comb begin
        case (insn[24:21])
            OP_AND:  alt = rn & op2;
            OP_EOR:  alt = rn ^ op2;
            OP_SUB:  alt = rn - op2;
            OP_RSB:  alt = op2 - rn;
            OP_ADD:  alt = rn + op2;
            OP_ADC:  alt = rn + op2 + cin;
            OP_SBC:  alt = rn + ~op2 + cin;
            OP_RSC:  alt = op2 + ~rn + cin;
            OP_ORR:  alt = rn | op2;
            OP_MOV:  alt = op2;
            OP_BIC:  alt = rn & ~op2;
            OP_MVN:  alt = ~op2;
            default: alt = 32'd0;
        endcase
    end

    // single load offset and address
    assign ls_off  = insn[25] ? sh_val : {20'd0, insn[11:0]};
    assign ls_addr = !insn[24] ? rn : (insn[23] ? rn + ls_off : rn - ls_off);

    // block load: address of the highest word
    assign reg_cnt = 5'($countones(insn[15:0]));
    always_comb begin
        if (insn[23]) begin
            ldm_off = {25'd0, reg_cnt, 2'b00} - (insn[24] ? 32'd0 : 32'd4);
        end else begin
            ldm_off = insn[24] ? 32'hFFFF_FFFC : 32'd0;
        end
    end

    assign br_disp = {{6{insn[23]}}, insn[23:0], 2'b00} + 32'd8;
    assign br_tgt  = i_instr_address + br_disp;

    always_comb begin
        o_result.kind   = KIND_NONE;
        o_result.target = 32'd0;
        case (cls)
            CLS_DP_REG, CLS_DP_IMM: begin
                if (insn[15:12] == REG_PC && alt != 32'd0) begin
                    o_result.kind   = KIND_DIRECT;
                    o_result.target = alt;
                end
            end
            CLS_LS_IMM, CLS_LS_REG: begin
                if (insn[20] && insn[15:12] == REG_PC) begin
                    o_result.kind   = KIND_LOAD;
                    o_result.target = ls_addr;
                end
            end
            CLS_LDM: begin
                if (insn[20] && insn[15]) begin
                    o_result.kind   = KIND_LOAD;
                    o_result.target = rn + ldm_off;
                end
            end
            CLS_BRANCH: begin
                if (br_disp != 32'd0 && br_disp != 32'd4 && br_tgt != 32'd0) begin
                    o_result.kind   = KIND_DIRECT;
                    o_result.target = br_tgt;
                end
            end
            default: begin
                o_result.kind = KIND_NONE;
            end
        endcase
        o_result.fall      = (o_result.kind == KIND_NONE) || (insn[31:28] != COND_AL);
        o_result.fall_addr = i_instr_address + 32'd4;
    end

endmodule

// File: rtl/core/arm_next_pc_target.sv
// Top level of the ARM next-PC target unit.
// Input register, target logic, result register. Uses anpt_pkg, anpt_target.
//
// Usage:
//   Request channel: i_in_valid / o_in_ready with the instruction word, its
//   address, the Rn, Rm and Rs values and the carry flag.
//   Result channel: o_out_valid / i_out_ready with target kind, target or
//   load address, fall-through flag and fall-through address.
//   Config: i_cfg_we / i_cfg_data write pc_mask, applied to Rn when Rn is PC.
//   Write it only while no request is in flight.
//
//   On acceptance the input register loads; the target logic works on it,
//   and the result register loads from it once the result stage is free.
//   Throughput is one request per cycle while the receiver takes results;
//   both stages then advance together.
//   Reset clears both stage valids and sets pc_mask to all ones.
//   When the receiver stalls the result register holds, the input stage
//   fills, and o_in_ready drops until the result is taken.
module arm_next_pc_target import anpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_instr_address,
    input  logic [31:0] i_rn_value,
    input  logic [31:0] i_rm_value,
    input  logic [31:0] i_rs_value,
    input  logic        i_carry_flag,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_target_kind,
    output logic [31:0] o_target_address,
    output logic        o_fallthrough_needed,
    output logic [31:0] o_fallthrough_address
);

    logic [31:0] r_pc_mask;
    logic        r_s1_valid;
    logic [31:0] r_instruction;
    logic [31:0] r_instr_address;
    logic [31:0] r_rn_value;
    logic [31:0] r_rm_value;
    logic [31:0] r_rs_value;
    logic        r_carry_flag;
    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;
    logic        out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc_mask <= PC_MASK_RESET;
        end else if (i_cfg_we) begin
            r_pc_mask <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_instruction   <= i_instruction;
            r_instr_address <= i_instr_address;
            r_rn_value      <= i_rn_value;
            r_rm_value      <= i_rm_value;
            r_rs_value      <= i_rs_value;
            r_carry_flag    <= i_carry_flag;
        end
    end

    anpt_target u_target (
        .i_instruction   (r_instruction),
        .i_instr_address (r_instr_address),
        .i_rn_value      (r_rn_value),
        .i_rm_value      (r_rm_value),
        .i_rs_value      (r_rs_value),
        .i_carry_flag    (r_carry_flag),
        .i_pc_mask       (r_pc_mask),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_target_kind         = r_result.kind;
    assign o_target_address      = r_result.target;
    assign o_fallthrough_needed  = r_result.fall;
    assign o_fallthrough_address = r_result.fall_addr;

endmodule

// File: rtl/core/anpt_checker.sv
// Port-level checks for the ARM next-PC target unit.
// Bound to arm_next_pc_target. Uses anpt_pkg.
module anpt_checker import anpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  o_target_kind,
    input  logic [31:0] o_target_address,
    input  logic        o_fallthrough_needed
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_target_address) && $stable(o_target_kind))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_target_kind != 2'd3)
        else $error("illegal target kind");

    a_none_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target_kind == KIND_NONE |->
            o_fallthrough_needed && o_target_address == 32'd0)
        else $error("no-target result without fall-through or with address");

    a_direct_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target_kind == KIND_DIRECT |-> o_target_address != 32'd0)
        else $error("direct target of zero");

endmodule

bind arm_next_pc_target anpt_checker u_anpt_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_target_kind        (o_target_kind),
    .o_target_address     (o_target_address),
    .o_fallthrough_needed (o_fallthrough_needed)
);
